FILE: hdl/ccta_pkg.sv
package ccta_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_INIT  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [2:0] ADDR_COLOR = 3'd0;
  localparam logic [2:0] ADDR_MXP   = 3'd4;

  localparam logic [3:0] CLOSE_LEN = 4'd4;

  typedef enum logic [2:0] {
    K_LIT,
    K_COLOR,
    K_ATTR,
    K_RESET_WHITE,
    K_TAG
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] arg;
    logic       close;
  } job_t;

  function automatic job_t make_job(kind_e kind, logic [7:0] arg);
    job_t j;
    j.kind  = kind;
    j.arg   = arg;
    j.close = 1'b0;
    return j;
  endfunction

  // arg of K_COLOR: bit 3 bold, bits 2:0 color digit
  function automatic job_t ansi_job(logic [7:0] c);
    job_t j;
    case (c)
      "d":      j = make_job(K_COLOR, 8'h00);
      "b":      j = make_job(K_COLOR, 8'h04);
      "E", "c": j = make_job(K_COLOR, 8'h06);
      "g":      j = make_job(K_COLOR, 8'h02);
      "m":      j = make_job(K_COLOR, 8'h05);
      "r":      j = make_job(K_COLOR, 8'h01);
      "w":      j = make_job(K_COLOR, 8'h07);
      "o", "y": j = make_job(K_COLOR, 8'h03);
      "B":      j = make_job(K_COLOR, 8'h0C);
      "e", "C": j = make_job(K_COLOR, 8'h0E);
      "G":      j = make_job(K_COLOR, 8'h0A);
      "M":      j = make_job(K_COLOR, 8'h0D);
      "R":      j = make_job(K_COLOR, 8'h09);
      "W":      j = make_job(K_COLOR, 8'h0F);
      "Y":      j = make_job(K_COLOR, 8'h0B);
      "D":      j = make_job(K_COLOR, 8'h08);
      "@":      j = make_job(K_ATTR, "1");
      "#":      j = make_job(K_ATTR, "5");
      CH_CARET: j = make_job(K_LIT, CH_CARET);
      default:  j = make_job(K_RESET_WHITE, 8'h00);
    endcase
    return j;
  endfunction

  function automatic logic [3:0] kind_len(kind_e kind);
    logic [3:0] n;
    unique case (kind)
      K_LIT:         n = 4'd1;
      K_COLOR:       n = 4'd7;
      K_ATTR:        n = 4'd4;
      K_RESET_WHITE: n = 4'd11;
      K_TAG:         n = 4'd8;
      default:       n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kind_byte(kind_e kind, logic [7:0] arg, logic [3:0] idx);
    logic [7:0] b;
    b = arg;
    unique case (kind)
      K_LIT: b = arg;
      K_COLOR: begin
        case (idx)
          4'd0:    b = CH_ESC;
          4'd1:    b = "[";
          4'd2:    b = {7'b0011000, arg[3]};
          4'd3:    b = ";";
          4'd4:    b = "3";
          4'd5:    b = {5'b00110, arg[2:0]};
          default: b = "m";
        endcase
      end
      K_ATTR: begin
        case (idx)
          4'd0:    b = CH_ESC;
          4'd1:    b = "[";
          4'd2:    b = arg;
          default: b = "m";
        endcase
      end
      K_RESET_WHITE: begin
        case (idx)
          4'd0, 4'd4: b = CH_ESC;
          4'd1, 4'd5: b = "[";
          4'd2, 4'd6: b = "0";
          4'd7:       b = ";";
          4'd8:       b = "3";
          4'd9:       b = "7";
          default:    b = "m";
        endcase
      end
      K_TAG: begin
        case (idx)
          4'd0:    b = CH_ESC;
          4'd1:    b = "[";
          4'd2:    b = "4";
          4'd3:    b = "z";
          4'd4:    b = "<";
          4'd5:    b = "c";
          4'd6:    b = {5'b00110, arg[2:0]};
          default: b = ">";
        endcase
      end
      default: b = arg;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] close_byte(logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = CH_ESC;
      4'd1:    b = "[";
      4'd2:    b = "3";
      default: b = "z";
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/ccta_front.sv
module ccta_front
  import ccta_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       color_en_i,
  input  logic       mxp_en_i,
  input  logic       in_valid_i,
  input  logic       full_i,
  input  logic       req_type_i,
  input  logic [7:0] char_in_i,
  output logic       push_o,
  output job_t       job_o
);

  logic       caret_q, caret_d;
  logic [7:0] prev_q, prev_d;
  logic       open_q, open_d;
  logic       accept;
  logic       emit;
  logic [7:0] code;
  logic       gen;
  job_t       lit_job;
  job_t       code_job;

  assign accept = in_valid_i & ~full_i;

  always_comb begin
    code_job = ansi_job(code);
    open_d   = open_q;
    if (mxp_en_i) begin
      case (code)
        "l": code_job = make_job(K_TAG, 8'h01);
        "e": code_job = make_job(K_TAG, 8'h02);
        "p": code_job = make_job(K_TAG, 8'h03);
        "s": code_job = make_job(K_TAG, 8'h04);
        "E": code_job = make_job(K_TAG, 8'h05);
        "o": code_job = make_job(K_TAG, 8'h06);
        default: code_job = ansi_job(code);
      endcase
      if (code_job.kind == K_TAG) begin
        open_d = 1'b1;
      end else if (code != CH_CARET) begin
        code_job.close = open_q;
        open_d         = 1'b0;
      end
    end
    if (!emit) begin
      open_d = open_q;
    end
  end

  always_comb begin
    caret_d = caret_q;
    prev_d  = prev_q;
    emit    = 1'b0;
    gen     = 1'b0;
    code    = char_in_i;
    lit_job = make_job(K_LIT, char_in_i);
    if (req_type_i) begin
      code    = CH_X;
      emit    = color_en_i;
      caret_d = 1'b0;
      prev_d  = CH_INIT;
    end else if (caret_q) begin
      caret_d = 1'b0;
      if (color_en_i) begin
        emit   = (char_in_i != prev_q) || (prev_q == CH_CARET);
        prev_d = char_in_i;
      end else if (char_in_i == CH_CARET) begin
        gen = 1'b1;
      end
    end else if (char_in_i == CH_CARET) begin
      caret_d = 1'b1;
    end else begin
      gen = 1'b1;
    end
  end

  assign push_o = accept & (emit | gen);
  assign job_o  = emit ? code_job : lit_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caret_q <= 1'b0;
      prev_q  <= CH_INIT;
      open_q  <= 1'b0;
    end else if (accept) begin
      caret_q <= caret_d;
      prev_q  <= prev_d;
      open_q  <= open_d;
    end
  end

endmodule

FILE: hdl/ccta_queue.sv
module ccta_queue
  import ccta_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

FILE: hdl/ccta_back.sv
module ccta_back
  import ccta_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic [3:0] pos_q, pos_d;
  logic [3:0] total;
  logic [3:0] rel;
  logic       advance;

  assign advance = valid_i & (~valid_q | ~out_stall_i);
  assign total   = job_i.close ? kind_len(job_i.kind) + CLOSE_LEN : kind_len(job_i.kind);
  assign rel     = job_i.close ? pos_q - CLOSE_LEN : pos_q;

  always_comb begin
    if (job_i.close && pos_q < CLOSE_LEN) begin
      byte_d = close_byte(pos_q);
    end else begin
      byte_d = kind_byte(job_i.kind, job_i.arg, rel);
    end
    last_d = (pos_q == total - 4'd1);
    pos_d  = pos_q;
    if (advance) begin
      pos_d = last_d ? 4'd0 : pos_q + 4'd1;
    end
  end

  assign pop_o = advance & last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= 4'd0;
    end else begin
      pos_q <= pos_d;
      if (advance) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign run_last_o  = last_q;

endmodule

FILE: hdl/caret_color_to_ansi_stream.sv
// An accepted word is written into the job queue, from which the expander registers its first output byte.
// Throughput: one input word per cycle for plain text, and one byte per cycle of an
// escape run of n bytes (up to 15) from the expander, while out_stall_i is low.
// Input stalls only when the job queue between classifier and expander is full.
// Reset (rst_ni low, asynchronous): no caret pending, last code '0', no MXP tag open,
// color_enable 1, mxp_enable 0, queue and output register empty.
module caret_color_to_ansi_stream
  import ccta_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o
);

  logic color_en_q;
  logic mxp_en_q;
  logic wr_en;
  logic full;
  logic push;
  logic pop;
  logic q_valid;
  job_t job_in;
  job_t job_head;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_en_q <= 1'b1;
      mxp_en_q   <= 1'b0;
    end else if (wr_en) begin
      if (paddr == ADDR_COLOR) begin
        color_en_q <= pwdata[0];
      end
      if (paddr == ADDR_MXP) begin
        mxp_en_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_COLOR) begin
      prdata = {31'd0, color_en_q};
    end else if (paddr == ADDR_MXP) begin
      prdata = {31'd0, mxp_en_q};
    end
  end

  assign in_stall_o = full;

  ccta_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .color_en_i (color_en_q),
    .mxp_en_i   (mxp_en_q),
    .in_valid_i (in_valid_i),
    .full_i     (full),
    .req_type_i (req_type_i),
    .char_in_i  (char_in_i),
    .push_o     (push),
    .job_o      (job_in)
  );

  ccta_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .job_o   (job_head)
  );

  ccta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .job_i       (job_head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

FILE: tb/tb_caret_color_to_ansi_stream.sv
module tb_caret_color_to_ansi_stream;
  import ccta_pkg::*;

  localparam logic REQ_TEXT = 1'b0;
  localparam logic REQ_END  = 1'b1;

  localparam int unsigned MAX_RUN      = 15;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned UNIT_ITEMS   = 30;

  class ansi_translator;
    bit         color_en;
    bit         mxp_en;
    bit         caret_pend;
    bit         tag_open;
    logic [7:0] last_code;
    logic [7:0] want_byte[$];
    bit         want_last[$];
    int         mismatches;

    function new();
      color_en   = 1'b1;
      mxp_en     = 1'b0;
      caret_pend = 1'b0;
      tag_open   = 1'b0;
      last_code  = CH_INIT;
      mismatches = 0;
    endfunction

    function string ansi_text(logic [7:0] c);
      case (c)
        "d":      return "\033[0;30m";
        "b":      return "\033[0;34m";
        "E", "c": return "\033[0;36m";
        "g":      return "\033[0;32m";
        "m":      return "\033[0;35m";
        "r":      return "\033[0;31m";
        "w":      return "\033[0;37m";
        "o", "y": return "\033[0;33m";
        "B":      return "\033[1;34m";
        "e", "C": return "\033[1;36m";
        "G":      return "\033[1;32m";
        "M":      return "\033[1;35m";
        "R":      return "\033[1;31m";
        "W":      return "\033[1;37m";
        "Y":      return "\033[1;33m";
        "D":      return "\033[1;30m";
        "@":      return "\033[1m";
        "#":      return "\033[5m";
        CH_CARET: return "^";
        default:  return "\033[0m\033[0;37m";
      endcase
    endfunction

    function string code_run(logic [7:0] c);
      string tag;
      tag = "";
      if (!mxp_en) return ansi_text(c);
      case (c)
        "l": tag = "<c1>";
        "e": tag = "<c2>";
        "p": tag = "<c3>";
        "s": tag = "<c4>";
        "E": tag = "<c5>";
        "o": tag = "<c6>";
        default: tag = "";
      endcase
      if (tag != "") begin
        tag_open = 1'b1;
        return {"\033[4z", tag};
      end
      if (c == CH_CARET) return "^";
      if (tag_open) begin
        tag_open = 1'b0;
        return {"\033[3z", ansi_text(c)};
      end
      return ansi_text(c);
    endfunction

    function void take_word(logic req, logic [7:0] ch);
      string run;
      bit    lit;
      int    n;
      run = "";
      lit = 1'b0;
      if (req == REQ_END) begin
        if (color_en) run = code_run(CH_X);
        caret_pend = 1'b0;
        last_code  = CH_INIT;
      end else if (caret_pend) begin
        caret_pend = 1'b0;
        if (color_en) begin
          if (ch != last_code || last_code == CH_CARET) run = code_run(ch);
          last_code = ch;
        end else if (ch == CH_CARET) begin
          run = "^";
        end
      end else if (ch == CH_CARET) begin
        caret_pend = 1'b1;
      end else begin
        lit = 1'b1;
      end
      if (lit) begin
        want_byte.push_back(ch);
        want_last.push_back(1'b1);
      end
      n = (run.len() > MAX_RUN) ? MAX_RUN : run.len();
      for (int k = 0; k < n; k++) begin
        want_byte.push_back(run[k]);
        want_last.push_back(k == n - 1);
      end
    endfunction

    function void match_byte(logic [7:0] b, logic last);
      logic [7:0] eb;
      bit         el;
      if (want_byte.size() == 0) begin
        $error("out_byte: no byte pending, actual %h", b);
        mismatches++;
        return;
      end
      eb = want_byte.pop_front();
      el = want_last.pop_front();
      if (b !== eb) begin
        $error("out_byte: expected %h, actual %h", eb, b);
        mismatches++;
      end
      if (last !== el) begin
        $error("run_last: expected %b, actual %b", el, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return want_byte.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        req_type_i;
  logic [7:0]  char_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        run_last_o;

  ansi_translator xlat;
  int             in_idle_pct;
  int             out_idle_pct;
  int             hold_cnt;
  int             sent_words;
  logic [7:0]     prev_pick;
  string          code_pool;

  caret_color_to_ansi_stream u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .char_in_i   (char_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) xlat.match_byte(out_byte_o, run_last_o);
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_COLOR) xlat.color_en = data[0];
    if (addr == ADDR_MXP) xlat.mxp_en = data[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (xlat.pending() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_mode(input bit color, input bit mxp);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait_idle();
    apb_write(ADDR_COLOR, {31'd0, color});
    apb_write(ADDR_MXP, {31'd0, mxp});
  endtask

  // call at a falling edge; returns at a falling edge with valid still high
  task automatic send_word(input logic req, input logic [7:0] ch);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    char_in_i  <= ch;
    do @(posedge clk_i); while (in_stall_o);
    xlat.take_word(req, ch);
    sent_words++;
    @(negedge clk_i);
  endtask

  task automatic send_mark(input logic [7:0] code);
    send_word(REQ_TEXT, CH_CARET);
    send_word(REQ_TEXT, code);
  endtask

  task automatic send_random(input int count);
    int         stop_at;
    int         r;
    logic [7:0] ch;
    stop_at = sent_words + count;
    while (sent_words < stop_at) begin
      r = $urandom_range(99);
      if (r < 35) begin
        ch = 8'($urandom_range(255));
        if (ch == CH_CARET) ch = 8'h20;
        send_word(REQ_TEXT, ch);
      end else if (r < 75) begin
        if ($urandom_range(9) < 8) ch = code_pool[$urandom_range(code_pool.len() - 1)];
        else ch = 8'($urandom_range(255));
        prev_pick = ch;
        send_mark(ch);
      end else if (r < 83) begin
        send_mark(prev_pick);
      end else if (r < 88) begin
        send_mark(CH_CARET);
      end else if (r < 94) begin
        send_word(REQ_END, 8'($urandom_range(255)));
      end else if (r < 97) begin
        send_word(REQ_TEXT, CH_CARET);
        send_word(REQ_END, 8'($urandom_range(255)));
      end else begin
        send_word(REQ_TEXT, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_modes();
    set_mode(1'b1, 1'b0);
    send_random(UNIT_ITEMS);
    set_mode(1'b1, 1'b1);
    send_random(UNIT_ITEMS);
    set_mode(1'b0, 1'b1);
    send_random(UNIT_ITEMS / 2);
    set_mode(1'b0, 1'b0);
    send_random(UNIT_ITEMS / 2);
  endtask

  initial begin
    xlat         = new();
    code_pool    = "dbcgmrwyBCGMRWYDEoe@#^lpsx";
    prev_pick    = "r";
    sent_words   = 0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_cnt     = 0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_TEXT;
    char_in_i    = '0;
    out_stall_i  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_mode(1'b1, 1'b0);
    send_word(REQ_TEXT, "A");
    send_word(REQ_TEXT, 8'h00);
    send_word(REQ_TEXT, 8'hFF);
    send_mark("r");
    send_mark("r");
    send_mark(CH_CARET);
    send_mark(CH_CARET);
    send_mark("@");
    send_mark(8'h00);
    send_word(REQ_TEXT, CH_CARET);
    send_word(REQ_END, 8'hFF);
    set_mode(1'b1, 1'b1);
    send_mark("l");
    send_mark("r");
    send_mark("E");
    send_word(REQ_END, 8'h00);
    set_mode(1'b0, 1'b1);
    send_mark("r");
    send_mark(CH_CARET);
    send_word(REQ_END, 8'h55);

    in_idle_pct  = 20;
    out_idle_pct = 51;
    run_modes();

    in_idle_pct  = 51;
    out_idle_pct = 20;
    run_modes();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_mode(1'b1, 1'b1);
    hold_cnt = HOLD_CYCLES;
    send_random(UNIT_ITEMS);
    run_modes();

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait_idle();
    repeat (20) @(negedge clk_i);
    if (xlat.mismatches == 0 && xlat.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
